FILE: hdl/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg: shared constants, types and helpers
// Sizes of the graph store, sequencer step codes and the status bundle that
// the datapath returns to the controller.
// ----------------------------------------------------------------------------
package scc_pkg;

	// graph capacity
	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;

	// field and index widths
	localparam int NODE_W  = 11;                      // node numbers 0..2047
	localparam int IDX_W   = $clog2(MAX_NODES);       // zero-based node index
	localparam int OFS_AW  = $clog2(MAX_NODES + 1);   // offset table address
	localparam int EDGE_AW = $clog2(MAX_EDGES);       // edge store address
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);   // edge count and loop index
	localparam int OFF_W   = $clog2(MAX_EDGES + 1);   // adjacency offsets

	// sequencer steps, issued to the datapath as its command
	localparam int STEP_W = 6;
	localparam logic [STEP_W-1:0] S_IDLE    = 6'd0;
	localparam logic [STEP_W-1:0] S_INIT    = 6'd1;
	localparam logic [STEP_W-1:0] S_CLR     = 6'd2;
	localparam logic [STEP_W-1:0] S_CNT_RD  = 6'd3;
	localparam logic [STEP_W-1:0] S_CNT_CHK = 6'd4;
	localparam logic [STEP_W-1:0] S_CNT_WR  = 6'd5;
	localparam logic [STEP_W-1:0] S_PFX_RD  = 6'd6;
	localparam logic [STEP_W-1:0] S_PFX_WR  = 6'd7;
	localparam logic [STEP_W-1:0] S_FIL_RD  = 6'd8;
	localparam logic [STEP_W-1:0] S_FIL_CHK = 6'd9;
	localparam logic [STEP_W-1:0] S_FIL_WR  = 6'd10;
	localparam logic [STEP_W-1:0] S_D_ROOT  = 6'd11;
	localparam logic [STEP_W-1:0] S_D_RCHK  = 6'd12;
	localparam logic [STEP_W-1:0] S_D_TOP   = 6'd13;
	localparam logic [STEP_W-1:0] S_D_CMP   = 6'd14;
	localparam logic [STEP_W-1:0] S_D_NB    = 6'd15;
	localparam logic [STEP_W-1:0] S_D_VIS   = 6'd16;
	localparam logic [STEP_W-1:0] S_D_POP   = 6'd17;
	localparam logic [STEP_W-1:0] S_CLR2    = 6'd18;
	localparam logic [STEP_W-1:0] S_K_ROOT  = 6'd19;
	localparam logic [STEP_W-1:0] S_K_RD    = 6'd20;
	localparam logic [STEP_W-1:0] S_K_CHK   = 6'd21;
	localparam logic [STEP_W-1:0] S_K_POP   = 6'd22;
	localparam logic [STEP_W-1:0] S_K_U     = 6'd23;
	localparam logic [STEP_W-1:0] S_K_J     = 6'd24;
	localparam logic [STEP_W-1:0] S_K_JT    = 6'd25;
	localparam logic [STEP_W-1:0] S_K_W     = 6'd26;
	localparam logic [STEP_W-1:0] S_K_WCHK  = 6'd27;
	localparam logic [STEP_W-1:0] S_M_E     = 6'd28;
	localparam logic [STEP_W-1:0] S_M_CHK   = 6'd29;
	localparam logic [STEP_W-1:0] S_M_C1    = 6'd30;
	localparam logic [STEP_W-1:0] S_M_C2    = 6'd31;
	localparam logic [STEP_W-1:0] S_N_RD    = 6'd32;
	localparam logic [STEP_W-1:0] S_N_ACC   = 6'd33;
	localparam logic [STEP_W-1:0] S_DONE    = 6'd34;

	// datapath status seen by the controller
	typedef struct packed {
		logic last_acc;    // closing item taken this cycle
		logic idx_at_nn;   // loop index reached node count
		logic idx_at_e;    // loop index reached stored edge count
		logic idx_zero;    // loop index is zero
		logic idx_at_comp; // loop index reached component count
		logic es_ok;       // stored edge passes the range check
		logic vis;         // visited mark just read
		logic cur_lt;      // forward cursor below end of adjacency
		logic j_lt;        // reverse scan pointer below end
		logic sp_one;      // one entry on the search stack
		logic sp_zero;     // search stack empty
		logic out_free;    // result register can take a new result
	} status_t;

	// node count clamped to the capacity
	function automatic logic [NODE_W-1:0] eff_nodes(input logic [NODE_W-1:0] nc);
		eff_nodes = (nc > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : nc;
	endfunction

	// both endpoints within 1..nn
	function automatic logic edge_ok(input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d,
		input logic [NODE_W-1:0] nn);
		edge_ok = (s != '0) && (s <= nn) && (d != '0) && (d <= nn);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/scc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_in_if: edge input channel
// Valid/ready channel carrying one edge item per transaction.
// ----------------------------------------------------------------------------
interface scc_in_if import scc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              has_edge;
	logic [NODE_W-1:0] edge_from;
	logic [NODE_W-1:0] edge_to;
	logic              last_item;

	modport source (output valid, output has_edge, output edge_from, output edge_to,
		output last_item, input ready);
	modport sink (input valid, input has_edge, input edge_from, input edge_to,
		input last_item, output ready);
endinterface
`default_nettype wire

FILE: hdl/scc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_out_if: result channel
// Valid/ready channel carrying one component count result per transaction.
// ----------------------------------------------------------------------------
interface scc_out_if import scc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] source_components;
	logic [NODE_W-1:0] component_total;
	logic              overflow;

	modport source (output valid, output source_components, output component_total,
		output overflow, input ready);
	modport sink (input valid, input source_components, input component_total,
		input overflow, output ready);
endinterface
`default_nettype wire

FILE: hdl/scc_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_cfg_if: configuration write channel
// Valid/ready channel carrying the node count register write data.
// ----------------------------------------------------------------------------
interface scc_cfg_if import scc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node_count;

	modport source (output valid, output node_count, input ready);
	modport sink (input valid, input node_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/scc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ctrl: sequencer
// Steps through loading, adjacency build, both search passes, edge marking
// and counting; issues its step to the datapath and branches on its status.
// ----------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire status_t           stat,
	output logic [STEP_W-1:0]      cmd
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	assign cmd = step_q;

	// next step
	always_comb begin
		step_d = step_q;
		unique case (step_q)
			S_IDLE:    if (stat.last_acc) step_d = S_INIT;
			S_INIT:    step_d = S_CLR;
			S_CLR:     if (stat.idx_at_nn) step_d = S_CNT_RD;
			S_CNT_RD:  step_d = stat.idx_at_e ? S_PFX_RD : S_CNT_CHK;
			S_CNT_CHK: step_d = stat.es_ok ? S_CNT_WR : S_CNT_RD;
			S_CNT_WR:  step_d = S_CNT_RD;
			S_PFX_RD:  step_d = stat.idx_at_nn ? S_FIL_RD : S_PFX_WR;
			S_PFX_WR:  step_d = S_PFX_RD;
			S_FIL_RD:  step_d = stat.idx_at_e ? S_D_ROOT : S_FIL_CHK;
			S_FIL_CHK: step_d = stat.es_ok ? S_FIL_WR : S_FIL_RD;
			S_FIL_WR:  step_d = S_FIL_RD;
			S_D_ROOT:  step_d = stat.idx_at_nn ? S_CLR2 : S_D_RCHK;
			S_D_RCHK:  step_d = stat.vis ? S_D_ROOT : S_D_TOP;
			S_D_TOP:   step_d = S_D_CMP;
			S_D_CMP: begin
				if (stat.cur_lt) step_d = S_D_NB;
				else if (stat.sp_one) step_d = S_D_ROOT;
				else step_d = S_D_POP;
			end
			S_D_NB:    step_d = S_D_VIS;
			S_D_VIS:   step_d = S_D_TOP;
			S_D_POP:   step_d = S_D_TOP;
			S_CLR2:    if (stat.idx_at_nn) step_d = S_K_ROOT;
			S_K_ROOT:  step_d = stat.idx_zero ? S_M_E : S_K_RD;
			S_K_RD:    step_d = S_K_CHK;
			S_K_CHK:   step_d = stat.vis ? S_K_ROOT : S_K_POP;
			S_K_POP:   step_d = stat.sp_zero ? S_K_ROOT : S_K_U;
			S_K_U:     step_d = S_K_J;
			S_K_J:     step_d = S_K_JT;
			S_K_JT:    step_d = stat.j_lt ? S_K_W : S_K_POP;
			S_K_W:     step_d = S_K_WCHK;
			S_K_WCHK:  step_d = S_K_JT;
			S_M_E:     step_d = stat.idx_at_e ? S_N_RD : S_M_CHK;
			S_M_CHK:   step_d = stat.es_ok ? S_M_C1 : S_M_E;
			S_M_C1:    step_d = S_M_C2;
			S_M_C2:    step_d = S_M_E;
			S_N_RD:    step_d = stat.idx_at_comp ? S_DONE : S_N_ACC;
			S_N_ACC:   step_d = S_N_RD;
			S_DONE:    if (stat.out_free) step_d = S_IDLE;
			default:   step_d = S_IDLE;
		endcase
	end

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/scc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_dpath: graph store and search datapath
// Holds the edge store, adjacency tables, marks, stack and labels, the loop
// counters and the result register; carries out each sequencer step.
// ----------------------------------------------------------------------------
module scc_dpath import scc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [STEP_W-1:0] cmd,
	output status_t                stat,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_has_edge,
	input  wire logic [NODE_W-1:0] in_from,
	input  wire logic [NODE_W-1:0] in_to,
	input  wire logic              in_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [NODE_W-1:0]      out_sources,
	output logic [NODE_W-1:0]      out_total,
	output logic                   out_overflow,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [NODE_W-1:0] cfg_data
);

	// control registers
	logic [NODE_W-1:0] nc_q, nn_q, sp_q, fin_q, comps_q, src_q;
	logic [ECNT_W-1:0] edges_q, idx_q;
	logic              drop_q, bad_q, out_valid_q;

	// working registers
	logic [IDX_W-1:0]  u_q, v_q, cs_q;
	logic [OFF_W-1:0]  acc_f_q, acc_r_q, j_q, jend_q;
	logic [NODE_W-1:0] res_src_q, res_tot_q;
	logic              res_ovf_q;

	// memories
	logic [2*NODE_W-1:0] es_mem   [MAX_EDGES];
	logic [OFF_W-1:0]    fo_mem   [MAX_NODES+1];
	logic [OFF_W-1:0]    ro_mem   [MAX_NODES+1];
	logic [OFF_W-1:0]    cf_mem   [MAX_NODES];
	logic [OFF_W-1:0]    cr_mem   [MAX_NODES];
	logic [IDX_W-1:0]    ft_mem   [MAX_EDGES];
	logic [IDX_W-1:0]    rt_mem   [MAX_EDGES];
	logic                vis_mem  [MAX_NODES];
	logic [IDX_W-1:0]    stk_mem  [MAX_NODES];
	logic [IDX_W-1:0]    fin_mem  [MAX_NODES];
	logic [IDX_W-1:0]    comp_mem [MAX_NODES];
	logic                ent_mem  [MAX_NODES];

	// registered read data
	logic [2*NODE_W-1:0] es_rd;
	logic [OFF_W-1:0]    fo_rd, ro_rd, cf_rd, cr_rd;
	logic [IDX_W-1:0]    ft_rd, rt_rd, stk_rd, fin_rd, comp_rd;
	logic                vis_rd, ent_rd;

	// memory controls
	logic                es_we;
	logic                fo_we, ro_we, cf_we, cr_we, ft_we, rt_we;
	logic                vis_we, stk_we, fin_we, comp_we, ent_we;
	logic [OFS_AW-1:0]   fo_wa, ro_wa, fo_ra, ro_ra;
	logic [OFF_W-1:0]    fo_wd, ro_wd, cf_wd, cr_wd;
	logic [IDX_W-1:0]    cf_wa, cr_wa, cf_ra, cr_ra;
	logic [EDGE_AW-1:0]  ft_wa, rt_wa;
	logic [IDX_W-1:0]    vis_wa, vis_ra, stk_wa, stk_ra, comp_wa, comp_ra, ent_wa;
	logic                vis_wd, ent_wd;

	// decoded edge and checks
	logic [NODE_W-1:0] es_s, es_d;
	logic [IDX_W-1:0]  s0, d0;
	logic              es_ok, in_ok, in_acc, out_free;
	logic [ECNT_W-1:0] nn_ext;

	assign es_s   = es_rd[2*NODE_W-1:NODE_W];
	assign es_d   = es_rd[NODE_W-1:0];
	assign s0     = IDX_W'(es_s - NODE_W'(1));
	assign d0     = IDX_W'(es_d - NODE_W'(1));
	assign es_ok  = edge_ok(es_s, es_d, nn_q);
	assign nn_ext = ECNT_W'(nn_q);
	assign in_acc = in_valid && (cmd == S_IDLE);
	assign in_ok  = edge_ok(in_from, in_to, eff_nodes(nc_q)) &&
		(edges_q < ECNT_W'(MAX_EDGES));
	assign es_we  = in_acc && in_has_edge && in_ok;
	assign out_free = !out_valid_q || out_ready;

	// handshake outputs
	assign in_ready     = (cmd == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign out_sources  = res_src_q;
	assign out_total    = res_tot_q;
	assign out_overflow = res_ovf_q;

	// status to the sequencer
	always_comb begin
		stat.last_acc    = in_acc && in_last;
		stat.idx_at_nn   = (idx_q == nn_ext);
		stat.idx_at_e    = (idx_q == edges_q);
		stat.idx_zero    = (idx_q == '0);
		stat.idx_at_comp = (idx_q == ECNT_W'(comps_q));
		stat.es_ok       = es_ok;
		stat.vis         = vis_rd;
		stat.cur_lt      = (cf_rd < fo_rd);
		stat.j_lt        = (j_q < jend_q);
		stat.sp_one      = (sp_q == NODE_W'(1));
		stat.sp_zero     = (sp_q == '0);
		stat.out_free    = out_free;
	end

	// read addresses
	always_comb begin
		unique case (cmd)
			S_CNT_CHK: begin
				fo_ra = OFS_AW'(es_s);
				ro_ra = OFS_AW'(es_d);
			end
			S_PFX_RD: begin
				fo_ra = OFS_AW'(idx_q + ECNT_W'(1));
				ro_ra = OFS_AW'(idx_q + ECNT_W'(1));
			end
			default: begin
				fo_ra = OFS_AW'(u_q) + OFS_AW'(1);
				ro_ra = OFS_AW'(stk_rd) + OFS_AW'(1);
			end
		endcase
		cf_ra   = (cmd == S_FIL_CHK) ? s0 : u_q;
		cr_ra   = (cmd == S_FIL_CHK) ? d0 : stk_rd;
		stk_ra  = (cmd == S_D_CMP) ? IDX_W'(sp_q - NODE_W'(2)) : IDX_W'(sp_q - NODE_W'(1));
		comp_ra = (cmd == S_M_C1) ? d0 : s0;
		unique case (cmd)
			S_D_NB:  vis_ra = ft_rd;
			S_K_RD:  vis_ra = fin_rd;
			S_K_W:   vis_ra = rt_rd;
			default: vis_ra = idx_q[IDX_W-1:0];
		endcase
	end

	// write controls per step
	always_comb begin
		fo_we   = 1'b0;
		fo_wa   = OFS_AW'(idx_q);
		fo_wd   = '0;
		ro_we   = 1'b0;
		ro_wa   = OFS_AW'(idx_q);
		ro_wd   = '0;
		cf_we   = 1'b0;
		cf_wa   = idx_q[IDX_W-1:0];
		cf_wd   = '0;
		cr_we   = 1'b0;
		cr_wa   = idx_q[IDX_W-1:0];
		cr_wd   = '0;
		ft_we   = 1'b0;
		ft_wa   = EDGE_AW'(cf_rd - OFF_W'(1));
		rt_we   = 1'b0;
		rt_wa   = EDGE_AW'(cr_rd - OFF_W'(1));
		vis_we  = 1'b0;
		vis_wa  = idx_q[IDX_W-1:0];
		vis_wd  = 1'b0;
		stk_we  = 1'b0;
		stk_wa  = sp_q[IDX_W-1:0];
		fin_we  = 1'b0;
		comp_we = 1'b0;
		comp_wa = v_q;
		ent_we  = 1'b0;
		ent_wa  = idx_q[IDX_W-1:0];
		ent_wd  = 1'b0;
		unique case (cmd)
			S_CLR: begin
				fo_we = 1'b1;
				ro_we = 1'b1;
				if (idx_q < nn_ext) begin
					vis_we = 1'b1;
					ent_we = 1'b1;
				end
			end
			S_CNT_WR: begin
				fo_we = 1'b1;
				fo_wa = OFS_AW'(es_s);
				fo_wd = fo_rd + OFF_W'(1);
				ro_we = 1'b1;
				ro_wa = OFS_AW'(es_d);
				ro_wd = ro_rd + OFF_W'(1);
			end
			S_PFX_WR: begin
				fo_we = 1'b1;
				fo_wa = OFS_AW'(idx_q + ECNT_W'(1));
				fo_wd = acc_f_q + fo_rd;
				ro_we = 1'b1;
				ro_wa = OFS_AW'(idx_q + ECNT_W'(1));
				ro_wd = acc_r_q + ro_rd;
				cf_we = 1'b1;
				cf_wd = acc_f_q + fo_rd;
				cr_we = 1'b1;
				cr_wd = acc_r_q + ro_rd;
			end
			S_FIL_WR: begin
				ft_we = 1'b1;
				rt_we = 1'b1;
				cf_we = 1'b1;
				cf_wa = s0;
				cf_wd = cf_rd - OFF_W'(1);
				cr_we = 1'b1;
				cr_wa = d0;
				cr_wd = cr_rd - OFF_W'(1);
			end
			S_D_RCHK: begin
				if (!vis_rd) begin
					vis_we = 1'b1;
					vis_wd = 1'b1;
					stk_we = 1'b1;
					stk_wa = '0;
				end
			end
			S_D_CMP: begin
				if (cf_rd < fo_rd) begin
					cf_we = 1'b1;
					cf_wa = u_q;
					cf_wd = cf_rd + OFF_W'(1);
				end else begin
					fin_we = 1'b1;
				end
			end
			S_D_VIS, S_K_WCHK: begin
				if (!vis_rd) begin
					vis_we  = 1'b1;
					vis_wa  = v_q;
					vis_wd  = 1'b1;
					stk_we  = 1'b1;
					comp_we = (cmd == S_K_WCHK);
				end
			end
			S_CLR2: begin
				if (idx_q < nn_ext) vis_we = 1'b1;
			end
			S_K_CHK: begin
				if (!vis_rd) begin
					vis_we  = 1'b1;
					vis_wa  = v_q;
					vis_wd  = 1'b1;
					stk_we  = 1'b1;
					stk_wa  = '0;
					comp_we = 1'b1;
				end
			end
			S_M_C2: begin
				if (cs_q != comp_rd) begin
					ent_we = 1'b1;
					ent_wa = comp_rd;
					ent_wd = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// edge store
	always_ff @(posedge clk) begin
		if (es_we) es_mem[edges_q[EDGE_AW-1:0]] <= {in_from, in_to};
		es_rd <= es_mem[idx_q[EDGE_AW-1:0]];
	end

	// offset tables
	always_ff @(posedge clk) begin
		if (fo_we) fo_mem[fo_wa] <= fo_wd;
		if (ro_we) ro_mem[ro_wa] <= ro_wd;
		fo_rd <= fo_mem[fo_ra];
		ro_rd <= ro_mem[ro_ra];
	end

	// insertion and scan cursors
	always_ff @(posedge clk) begin
		if (cf_we) cf_mem[cf_wa] <= cf_wd;
		if (cr_we) cr_mem[cr_wa] <= cr_wd;
		cf_rd <= cf_mem[cf_ra];
		cr_rd <= cr_mem[cr_ra];
	end

	// adjacency targets, reversed fill order within a node
	always_ff @(posedge clk) begin
		if (ft_we) ft_mem[ft_wa] <= d0;
		if (rt_we) rt_mem[rt_wa] <= s0;
		ft_rd <= ft_mem[cf_rd[EDGE_AW-1:0]];
		rt_rd <= rt_mem[j_q[EDGE_AW-1:0]];
	end

	// visited marks and search stack
	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		if (stk_we) stk_mem[stk_wa] <= (cmd == S_D_RCHK) ? idx_q[IDX_W-1:0] : v_q;
		vis_rd <= vis_mem[vis_ra];
		stk_rd <= stk_mem[stk_ra];
	end

	// finish order, component labels and entered marks
	always_ff @(posedge clk) begin
		if (fin_we) fin_mem[fin_q[IDX_W-1:0]] <= u_q;
		if (comp_we) comp_mem[comp_wa] <= comps_q[IDX_W-1:0];
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		fin_rd  <= fin_mem[IDX_W'(idx_q - ECNT_W'(1))];
		comp_rd <= comp_mem[comp_ra];
		ent_rd  <= ent_mem[idx_q[IDX_W-1:0]];
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q        <= NODE_W'(1);
			nn_q        <= '0;
			edges_q     <= '0;
			idx_q       <= '0;
			sp_q        <= '0;
			fin_q       <= '0;
			comps_q     <= '0;
			src_q       <= '0;
			drop_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) nc_q <= cfg_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (cmd)
				S_IDLE: begin
					if (in_acc && in_has_edge) begin
						if (in_ok) edges_q <= edges_q + ECNT_W'(1);
						else drop_q <= 1'b1;
					end
				end
				S_INIT: begin
					nn_q    <= eff_nodes(nc_q);
					idx_q   <= '0;
					fin_q   <= '0;
					comps_q <= '0;
					src_q   <= '0;
					bad_q   <= 1'b0;
				end
				S_CLR: idx_q <= stat.idx_at_nn ? '0 : idx_q + ECNT_W'(1);
				S_CNT_RD, S_FIL_RD, S_M_E: begin
					if (stat.idx_at_e) idx_q <= '0;
				end
				S_CNT_CHK, S_FIL_CHK, S_M_CHK: begin
					if (!es_ok) begin
						idx_q <= idx_q + ECNT_W'(1);
						bad_q <= 1'b1;
					end
				end
				S_CNT_WR, S_PFX_WR, S_FIL_WR, S_M_C2: idx_q <= idx_q + ECNT_W'(1);
				S_PFX_RD, S_D_ROOT: begin
					if (stat.idx_at_nn) idx_q <= '0;
				end
				S_D_RCHK: begin
					if (vis_rd) idx_q <= idx_q + ECNT_W'(1);
					else sp_q <= NODE_W'(1);
				end
				S_D_CMP: begin
					if (!stat.cur_lt) begin
						fin_q <= fin_q + NODE_W'(1);
						sp_q  <= sp_q - NODE_W'(1);
						if (stat.sp_one) idx_q <= idx_q + ECNT_W'(1);
					end
				end
				S_D_VIS, S_K_WCHK: begin
					if (!vis_rd) sp_q <= sp_q + NODE_W'(1);
				end
				S_CLR2: idx_q <= stat.idx_at_nn ? ECNT_W'(fin_q) : idx_q + ECNT_W'(1);
				S_K_CHK: begin
					idx_q <= idx_q - ECNT_W'(1);
					if (!vis_rd) sp_q <= NODE_W'(1);
				end
				S_K_POP: begin
					if (stat.sp_zero) comps_q <= comps_q + NODE_W'(1);
					else sp_q <= sp_q - NODE_W'(1);
				end
				S_N_ACC: begin
					idx_q <= idx_q + ECNT_W'(1);
					if (!ent_rd) src_q <= src_q + NODE_W'(1);
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						edges_q     <= '0;
						drop_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working values and result payload
	always_ff @(posedge clk) begin
		unique case (cmd)
			S_INIT: begin
				acc_f_q <= '0;
				acc_r_q <= '0;
			end
			S_PFX_WR: begin
				acc_f_q <= acc_f_q + fo_rd;
				acc_r_q <= acc_r_q + ro_rd;
			end
			S_D_RCHK: u_q <= idx_q[IDX_W-1:0];
			S_D_VIS:  if (!vis_rd) u_q <= v_q;
			S_D_POP:  u_q <= stk_rd;
			S_D_NB:   v_q <= ft_rd;
			S_K_RD:   v_q <= fin_rd;
			S_K_W:    v_q <= rt_rd;
			S_K_J: begin
				j_q    <= cr_rd;
				jend_q <= ro_rd;
			end
			S_K_JT:   if (j_q < jend_q) j_q <= j_q + OFF_W'(1);
			S_M_C1:   cs_q <= comp_rd;
			S_DONE: begin
				if (out_free) begin
					res_src_q <= src_q;
					res_tot_q <= comps_q;
					res_ovf_q <= drop_q | bad_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/scc_source_component_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scc_source_component_counter_unit: strongly connected component counter
// Loads a directed graph edge by edge, then counts its strongly connected
// components and those that no edge from another component enters.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch sets the node count (nodes 1..n, clamped to 1024); write it only
//   while the block is idle. in_ch takes one edge item per cycle while the
//   block is loading; bad or surplus edges are dropped and flag overflow.
//   The item with last_item set closes the graph and starts the search.
//   While the search runs in_ch.ready is low. One result leaves on out_ch.
// Throughput:
//   loading runs at one item per cycle. After the closing item the build,
//   both search passes, edge marking and counting run one after another;
//   in_ch takes no new item until the result is in the result register.
// Reset and stalls:
//   reset sets node count to 1 and empties the edge store; the offset
//   tables and marks get a clearing pass before each search. The result
//   register holds a result until taken; the next graph can load meanwhile,
//   and its result waits for the register to free before loading resumes.
// ----------------------------------------------------------------------------
module scc_source_component_counter_unit import scc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	scc_in_if.sink     in_ch,
	scc_out_if.source  out_ch,
	scc_cfg_if.sink    cfg_ch
);

	logic [STEP_W-1:0] cmd;
	status_t           stat;

	// sequencer
	scc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// graph store and search datapath
	scc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_has_edge  (in_ch.has_edge),
		.in_from      (in_ch.edge_from),
		.in_to        (in_ch.edge_to),
		.in_last      (in_ch.last_item),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_sources  (out_ch.source_components),
		.out_total    (out_ch.component_total),
		.out_overflow (out_ch.overflow),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.node_count)
	);

endmodule
`default_nettype wire

FILE: tb/scc_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_tb_if: testbench-side interface file
// The channel interfaces live with the RTL; this file only holds the
// item types that the testbench queues carry.
// ----------------------------------------------------------------------------
package scc_tb_types;
	import scc_pkg::*;

	// one edge item
	typedef struct packed {
		logic              has_edge;
		logic [NODE_W-1:0] edge_from;
		logic [NODE_W-1:0] edge_to;
		logic              last_item;
	} edge_item_t;

	// one count result
	typedef struct packed {
		logic [NODE_W-1:0] source_components;
		logic [NODE_W-1:0] component_total;
		logic              overflow;
	} count_result_t;
endpackage

FILE: tb/scc_source_component_counter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_source_component_counter_unit_tb: self-checking bench for the counter
// Loads random and directed graphs, predicts the component counts with an
// independent Kosaraju search and checks every result transaction.
// ----------------------------------------------------------------------------
module scc_source_component_counter_unit_tb;
	import scc_pkg::*;
	import scc_tb_types::*;

	localparam int WATCHDOG_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scc_in_if  in_ch ();
	scc_out_if out_ch ();
	scc_cfg_if cfg_ch ();

	scc_source_component_counter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// clock
	always #5 clk = ~clk;

	// pending edges and expected counts
	edge_item_t    pending_edges[$];
	count_result_t expected_counts[$];
	int errors = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_sink = 1'b0;
	bit hold_go = 1'b0;
	bit feed_on = 1'b0;
	bit send_done = 1'b0;
	bit in_taken = 1'b0;

	// predictor state
	int unsigned mdl_nodes = 1;
	int unsigned mdl_src[$];
	int unsigned mdl_dst[$];
	bit mdl_dropped = 1'b0;

	// counts components of the held graph and its source components
	function automatic count_result_t count_components(int unsigned nc);
		int unsigned nn;
		int fwd[][$];
		int rev[][$];
		int order[$];
		int stk[$];
		int cur[];
		int comp[];
		bit seen[];
		bit hit[];
		bit bad;
		int ncomp, nsrc, u, v;
		count_result_t r;
		nn = (nc > MAX_NODES) ? MAX_NODES : nc;
		bad = 1'b0;
		ncomp = 0;
		nsrc = 0;
		cur = new[nn];
		comp = new[nn];
		seen = new[nn];
		hit = new[nn];
		fwd = new[nn];
		rev = new[nn];
		for (int e = 0; e < mdl_src.size(); e++) begin
			if (mdl_src[e] < 1 || mdl_src[e] > nn || mdl_dst[e] < 1 || mdl_dst[e] > nn) begin
				bad = 1'b1;
				continue;
			end
			fwd[mdl_src[e]-1] = {fwd[mdl_src[e]-1], int'(mdl_dst[e]-1)};
			rev[mdl_dst[e]-1] = {rev[mdl_dst[e]-1], int'(mdl_src[e]-1)};
		end
		// first pass: finishing order
		for (int rt = 0; rt < nn; rt++) begin
			if (seen[rt]) continue;
			seen[rt] = 1'b1;
			cur[rt] = 0;
			stk = {stk, rt};
			while (stk.size() > 0) begin
				u = stk[$];
				if (cur[u] < fwd[u].size()) begin
					v = fwd[u][cur[u]];
					cur[u]++;
					if (!seen[v]) begin
						seen[v] = 1'b1;
						cur[v] = 0;
						stk = {stk, v};
					end
				end else begin
					order = {order, u};
					void'(stk.pop_back());
				end
			end
		end
		// second pass on the reversed graph
		foreach (seen[i]) seen[i] = 1'b0;
		for (int k = order.size() - 1; k >= 0; k--) begin
			if (seen[order[k]]) continue;
			seen[order[k]] = 1'b1;
			comp[order[k]] = ncomp;
			stk = {stk, order[k]};
			while (stk.size() > 0) begin
				u = stk.pop_back();
				foreach (rev[u][j]) begin
					if (!seen[rev[u][j]]) begin
						seen[rev[u][j]] = 1'b1;
						comp[rev[u][j]] = ncomp;
						stk = {stk, rev[u][j]};
					end
				end
			end
			ncomp++;
		end
		// mark entered components
		for (int a = 0; a < nn; a++)
			foreach (fwd[a][j])
				if (comp[a] != comp[fwd[a][j]]) hit[comp[fwd[a][j]]] = 1'b1;
		for (int k = 0; k < ncomp; k++) if (!hit[k]) nsrc++;
		r.source_components = NODE_W'(nsrc);
		r.component_total   = NODE_W'(ncomp);
		r.overflow          = mdl_dropped | bad;
		return r;
	endfunction

	// predictor step for one accepted edge item
	task automatic predict_item(edge_item_t it);
		int unsigned nn;
		nn = (mdl_nodes > MAX_NODES) ? MAX_NODES : mdl_nodes;
		if (it.has_edge) begin
			if (it.edge_from >= 1 && it.edge_from <= nn && it.edge_to >= 1 &&
				it.edge_to <= nn && mdl_src.size() < MAX_EDGES) begin
				mdl_src = {mdl_src, int'(it.edge_from)};
				mdl_dst = {mdl_dst, int'(it.edge_to)};
			end else
				mdl_dropped = 1'b1;
		end
		if (it.last_item) begin
			expected_counts = {expected_counts, count_components(mdl_nodes)};
			mdl_src.delete();
			mdl_dst.delete();
			mdl_dropped = 1'b0;
		end
	endtask

	// driver: offers queued edges at the falling edge, holds an offer until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_taken) begin
			in_ch.valid <= 1'b1;
		end else if (feed_on && pending_edges.size() > 0 &&
			(no_idle || $urandom_range(99) >= 34)) begin
			{in_ch.has_edge, in_ch.edge_from, in_ch.edge_to, in_ch.last_item}
				<= pending_edges[0];
			in_ch.valid <= 1'b1;
		end else begin
			in_ch.valid <= 1'b0;
		end
		in_taken = 1'b0;
	end

	// monitor of accepted edge transactions
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			predict_item({in_ch.has_edge, in_ch.edge_from, in_ch.edge_to, in_ch.last_item});
			void'(pending_edges.pop_front());
			in_taken = 1'b1;
		end
	end

	// result sink with random stalls
	always @(negedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else out_ch.ready <= !hold_sink && (no_idle || $urandom_range(99) >= 34);
	end

	// long receiver hold-off, timed in its own process
	initial begin
		wait (hold_go);
		hold_sink = 1'b1;
		repeat (3000) @(posedge clk);
		hold_sink = 1'b0;
	end

	// result checker
	always @(posedge clk) begin
		count_result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.source_components, out_ch.component_total, out_ch.overflow};
			if (expected_counts.size() == 0) begin
				$display("%0t: result expected none actual %h", $time, got);
				errors++;
			end else begin
				want = expected_counts.pop_front();
				if (got.source_components != want.source_components)
					$display("%0t: source_components expected %0d actual %0d", $time,
						want.source_components, got.source_components);
				if (got.component_total != want.component_total)
					$display("%0t: component_total expected %0d actual %0d", $time,
						want.component_total, got.component_total);
				if (got.overflow != want.overflow)
					$display("%0t: overflow expected %0d actual %0d", $time,
						want.overflow, got.overflow);
				if (got != want) errors++;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready) || send_done || !feed_on)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// wait until the block has drained every result
	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_edges.size() > 0 || in_ch.valid || expected_counts.size() > 0) &&
			guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
		repeat (50) @(posedge clk);
	endtask

	// node count register write between phases
	task automatic set_nodes(int unsigned n);
		drain();
		feed_on = 1'b0;
		@(negedge clk);
		cfg_ch.node_count <= NODE_W'(n);
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		mdl_nodes = n;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		feed_on = 1'b1;
	endtask

	function automatic void push_edge(int unsigned s, int unsigned d, bit last, bit he = 1'b1);
		edge_item_t it;
		it.has_edge = he;
		it.edge_from = NODE_W'(s);
		it.edge_to = NODE_W'(d);
		it.last_item = last;
		pending_edges = {pending_edges, it};
	endfunction

	// random graph over n nodes, mostly well formed
	function automatic void push_graph(int unsigned n, int unsigned m);
		int unsigned s, d;
		for (int i = 0; i < m; i++) begin
			s = $urandom_range(n, 1);
			d = $urandom_range(n, 1);
			if ($urandom_range(99) < 4) s = $urandom_range(2047);
			if ($urandom_range(99) < 4) d = $urandom_range(2047);
			push_edge(s, d, 1'b0, $urandom_range(99) >= 5);
		end
		push_edge($urandom_range(n, 1), $urandom_range(n, 1), 1'b1, $urandom_range(1));
	endfunction

	// stimulus
	initial begin
		int unsigned n;
		in_ch.valid = 1'b0;
		in_ch.has_edge = 1'b0;
		in_ch.edge_from = '0;
		in_ch.edge_to = '0;
		in_ch.last_item = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.node_count = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		feed_on = 1'b1;

		// directed: reset node count, empty graph, self loop, out-of-range edge
		push_edge(0, 0, 1'b1, 1'b0);
		push_edge(1, 1, 1'b1);
		push_edge(2, 1, 1'b1);
		set_nodes(5);
		// cycle 1-2-3 feeding 4, isolated 5, bad endpoints
		push_edge(1, 2, 1'b0);
		push_edge(2, 3, 1'b0);
		push_edge(3, 1, 1'b0);
		push_edge(3, 4, 1'b0);
		push_edge(0, 4, 1'b0);
		push_edge(4, 6, 1'b0);
		push_edge(4, 4, 1'b1);
		// graph loaded, then node count shrunk before closing
		push_edge(5, 4, 1'b0);
		push_edge(1, 2, 1'b0);
		set_nodes(3);
		push_edge(2, 1, 1'b1);
		set_nodes(0);
		push_edge(1, 1, 1'b0);
		push_edge(0, 0, 1'b1);
		set_nodes(2047);
		push_edge(1024, 1, 1'b0);
		push_edge(1, 1024, 1'b0);
		push_edge(1025, 2047, 1'b0);
		push_edge(2047, 2047, 1'b1);
		set_nodes(1024);
		// sparse random graph at full node count
		for (int i = 0; i < 230; i++)
			push_edge($urandom_range(1024, 1), $urandom_range(1024, 1), 1'b0);
		push_edge(0, 0, 1'b1, 1'b0);

		// receiver holds off while the sender keeps offering
		set_nodes(6);
		hold_go = 1'b1;
		for (int g = 0; g < 4; g++) push_graph(6, 6);

		// random graphs, mostly small, stretch without idling in the middle
		for (int ph = 0; ph < 12; ph++) begin
			n = (ph == 5) ? $urandom_range(200, 100) : $urandom_range(12, 1);
			if (ph == 7) n = 1;
			set_nodes(n);
			no_idle = (ph == 3 || ph == 4);
			for (int g = 0; g < 6; g++) push_graph(n, $urandom_range(10));
		end
		no_idle = 1'b0;

		drain();
		send_done = 1'b1;
		if (errors == 0 && expected_counts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
